>>> src/olsd_pkg.sv
// shared types and codes for the ordered list with search and delete
package olsd_pkg;

  // operation codes carried by a transaction
  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_DELETE    = 3'd4,
    OP_SEARCH    = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // per-cell load and shift controls
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

>>> src/olsd_cell.sv
// one list cell: holds an entry, compares it and shifts to either neighbor
module olsd_cell (
  input  logic                     clk,
  input  olsd_pkg::cell_ctrl_t     ctrl,
  input  logic signed [31:0]       key,
  input  logic signed [31:0]       left,
  input  logic signed [31:0]       right,
  output logic signed [31:0]       entry,
  output logic                     match
);

  // entry register, load wins over shifts, otherwise hold
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      entry <= key;
    end else if (ctrl.take_left) begin
      entry <= left;
    end else if (ctrl.take_right) begin
      entry <= right;
    end else begin
      entry <= entry;
    end
  end

  // equality against the search key
  assign match = (entry == key);

endmodule

>>> src/olsd_first_match.sv
// iterative reduction that finds the lowest position with a match bit set
module olsd_first_match #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [N-1:0]  match,
  output logic          done,
  output logic          found,
  output logic [IW-1:0] pos
);

  localparam int NP = 2 ** IW;
  localparam int SW = $clog2(IW + 1);

  logic          any_q      [NP];
  logic [IW-1:0] idx_q      [NP];
  logic          any_next   [NP];
  logic [IW-1:0] idx_next   [NP];
  logic          running;
  logic [SW-1:0] step;
  logic          done_q;

  // load leaves, or fold pairs into the lower half, lower index first
  always_comb begin
    for (int j = 0; j < NP; j++) begin
      any_next[j] = any_q[j];
      idx_next[j] = idx_q[j];
    end
    if (load) begin
      for (int j = 0; j < NP; j++) begin
        any_next[j] = (j < N) ? match[j % N] : 1'b0;
        idx_next[j] = IW'(j);
      end
    end else if (running) begin
      for (int j = 0; j < NP / 2; j++) begin
        any_next[j] = any_q[2*j] | any_q[2*j+1];
        idx_next[j] = any_q[2*j] ? idx_q[2*j] : idx_q[2*j+1];
      end
    end
  end

  // node registers
  always_ff @(posedge clk) begin
    for (int j = 0; j < NP; j++) begin
      any_q[j] <= any_next[j];
      idx_q[j] <= idx_next[j];
    end
  end

  // step counter, one tree level per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (load) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == SW'(IW - 1)) begin
          running <= 1'b0;
          done_q  <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign done  = done_q;
  assign found = any_q[0];
  assign pos   = idx_q[0];

endmodule

>>> src/ordered_list_with_search_delete_unit.sv
// top level of the bounded ordered list with push, pop, search and delete
//
//  channel   signals                                  handshake
//  command   op, value                                start, busy
//  result    data, found, status, entry_count         strobe
//
// push, pop, clear and any operation on an empty list: result in the
// cycle after the command, busy stays low, one command per cycle.
// search and delete on a non-empty list: busy until the first-match
// reduction, which folds one tree level per cycle, has finished, and
// no new command is taken while busy.
// reset empties the list; entry storage is not cleared.
// results cannot be stalled; each strobe lasts one cycle.
module ordered_list_with_search_delete_unit #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic signed [31:0] data,
  output logic               found,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIND = 2'b10
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic                   is_delete, is_delete_next;
  logic                   strobe_next;
  logic signed [31:0]     data_q, data_next;
  logic                   found_q, found_next;
  olsd_pkg::status_t      status_q, status_next;

  olsd_pkg::cell_ctrl_t   ctrl  [LIST_DEPTH];
  logic signed [31:0]     entry [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  cell_match;
  logic [LIST_DEPTH-1:0]  match;
  logic [LIST_DEPTH-1:0]  active;
  logic [LIST_DEPTH-1:0]  is_tail;
  logic signed [31:0]     tail_word;
  logic                   accept;
  logic                   empty;
  logic                   full;
  olsd_pkg::op_t          opc;
  logic                   fm_load;
  logic                   fm_done;
  logic                   fm_found;
  logic [IW-1:0]          fm_pos;
  logic [31:0]            count_wide;

  assign accept = start && !busy;
  assign busy   = (state == S_FIND);
  assign empty  = (count == '0);
  assign full   = (count == CW'(LIST_DEPTH));
  assign opc    = olsd_pkg::op_t'(op);

  // row of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    olsd_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl[i]),
      .key   (value),
      .left  ((i == 0) ? entry[i] : entry[(i + LIST_DEPTH - 1) % LIST_DEPTH]),
      .right ((i == LIST_DEPTH - 1) ? entry[i] : entry[(i + 1) % LIST_DEPTH]),
      .entry (entry[i]),
      .match (cell_match[i])
    );
    assign active[i] = (CW'(i) < count);
    assign is_tail[i] = (CW'(i + 1) == count);
    assign match[i]  = cell_match[i] && active[i];
  end

  // tail word select for pop tail
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      tail_word = tail_word | (is_tail[i] ? entry[i] : 32'sd0);
    end
  end

  // first-match search
  olsd_first_match #(
    .N  (LIST_DEPTH),
    .IW (IW)
  ) u_first_match (
    .clk   (clk),
    .rst   (rst),
    .load  (fm_load),
    .match (match),
    .done  (fm_done),
    .found (fm_found),
    .pos   (fm_pos)
  );

  // operation decode and cell controls
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ctrl[i] = '0;
    end
    state_next     = state;
    count_next     = count;
    is_delete_next = is_delete;
    strobe_next    = 1'b0;
    data_next      = '0;
    found_next     = 1'b0;
    status_next    = olsd_pkg::ST_OK;
    fm_load        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          unique case (opc)
            olsd_pkg::OP_PUSH_HEAD: begin
              if (full) begin
                status_next = olsd_pkg::ST_FULL;
              end else begin
                ctrl[0].load = 1'b1;
                for (int i = 1; i < LIST_DEPTH; i++) begin
                  ctrl[i].take_left = 1'b1;
                end
                count_next = count + 1'b1;
              end
            end
            olsd_pkg::OP_PUSH_TAIL: begin
              if (full) begin
                status_next = olsd_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < LIST_DEPTH; i++) begin
                  ctrl[i].load = (CW'(i) == count);
                end
                count_next = count + 1'b1;
              end
            end
            olsd_pkg::OP_POP_HEAD: begin
              if (empty) begin
                status_next = olsd_pkg::ST_EMPTY;
              end else begin
                data_next = entry[0];
                for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                  ctrl[i].take_right = 1'b1;
                end
                count_next = count - 1'b1;
              end
            end
            olsd_pkg::OP_POP_TAIL: begin
              if (empty) begin
                status_next = olsd_pkg::ST_EMPTY;
              end else begin
                data_next  = tail_word;
                count_next = count - 1'b1;
              end
            end
            olsd_pkg::OP_DELETE, olsd_pkg::OP_SEARCH: begin
              if (empty) begin
                status_next = olsd_pkg::ST_EMPTY;
              end else begin
                strobe_next    = 1'b0;
                fm_load        = 1'b1;
                is_delete_next = (opc == olsd_pkg::OP_DELETE);
                state_next     = S_FIND;
              end
            end
            olsd_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND: begin
        if (fm_done) begin
          strobe_next = 1'b1;
          state_next  = S_IDLE;
          if (fm_found) begin
            found_next = 1'b1;
            if (is_delete) begin
              for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                ctrl[i].take_right = (IW'(i) >= fm_pos);
              end
              count_next = count - 1'b1;
            end
          end else begin
            status_next = olsd_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      strobe    <= 1'b0;
      is_delete <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      strobe    <= strobe_next;
      is_delete <= is_delete_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    data_q   <= data_next;
    found_q  <= found_next;
    status_q <= status_next;
  end

  assign count_wide  = 32'(count);
  assign data        = data_q;
  assign found       = found_q;
  assign status      = status_q;
  assign entry_count = count_wide[4:0];

  // simple operations answer in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && opc != olsd_pkg::OP_DELETE && opc != olsd_pkg::OP_SEARCH) |=> strobe)
    else $error("no result after a single-cycle operation");

  // fill count stays within the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LIST_DEPTH))
    else $error("fill count beyond list depth");

  // a match always reports ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && found) |-> (status_q == olsd_pkg::ST_OK))
    else $error("match reported with a failing status");

  // no result while a search is under way
  a_busy_quiet: assert property (@(posedge clk) disable iff (rst)
    busy |-> !strobe)
    else $error("result strobe during a search");

  // delete drops the count by at most one
  a_delete_step: assert property (@(posedge clk) disable iff (rst)
    (busy && fm_done) |=> (count == $past(count) || count == $past(count) - 1'b1))
    else $error("count changed by more than one on delete");

endmodule
